// ===== hdl/phfa_pkg.sv =====
// Shared types and constants for the pair histogram fold accumulator.
// No dependencies; the square-root unit, the top level and the checker import this package.
package phfa_pkg;

    // Histogram geometry
    localparam int MAX_ETA_BINS   = 16;
    localparam int MAX_PHI_BINS   = 32;
    localparam int FOLD_ETA_SLOTS = 2 * MAX_ETA_BINS - 1;
    localparam int FOLD_DEPTH     = FOLD_ETA_SLOTS * MAX_PHI_BINS;
    localparam int ADDR_W         = $clog2(FOLD_DEPTH);

    // Register and field widths
    localparam int ETA_REG_W = 5;
    localparam int PHI_REG_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int VAL_IN_W  = 32;
    localparam int ERR_IN_W  = 31;
    localparam int SQ_W      = 2 * ERR_IN_W;
    localparam int VAL_SUM_W = 41;
    localparam int ERR_SUM_W = 64;
    localparam int ROOT_W    = ERR_SUM_W / 2;

    // Reset values of the registers
    localparam logic [ETA_REG_W-1:0] ETA_BINS_RST = ETA_REG_W'(16);
    localparam logic [PHI_REG_W-1:0] PHI_BINS_RST = PHI_REG_W'(32);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_BINS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHI_BINS = CFG_IDX_W'(1);

    // Request modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Control from the top level to the square-root unit
    typedef struct packed {
        logic start;
        logic ack;
    } t_sqrt_ctl;

    // Status from the square-root unit to the top level
    typedef struct packed {
        logic busy;
        logic valid;
    } t_sqrt_sts;

endpackage

// ===== hdl/phfa_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// A read that meets a write to the same address returns the old contents.
module phfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/phfa_sqrt.sv =====
// Bit-serial integer square root: one root bit per cycle, result held until taken.
// Depends on phfa_pkg for widths and the control and status structs.
module phfa_sqrt
    import phfa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sqrt_ctl            i_ctl,
    input  logic [ERR_SUM_W-1:0] i_operand,
    output t_sqrt_sts            o_sts,
    output logic [ROOT_W-1:0]    o_root
);

    localparam int RemW = ROOT_W + 3;
    localparam int CntW = $clog2(ROOT_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [CntW-1:0]      r_cnt;
    logic [ERR_SUM_W-1:0] r_x;
    logic [RemW-1:0]      r_rem;
    logic [ROOT_W-1:0]    r_root;

    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic            take;

    // One restoring step: bring down two operand bits, try root*4+1
    assign rem_sh = {r_rem[RemW-3:0], r_x[ERR_SUM_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    // Sequence idle, iterate, hold result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_ctl.start) n_state = ST_RUN;
            ST_RUN:  if (r_cnt == CntW'(ROOT_W - 1)) n_state = ST_DONE;
            ST_DONE: if (i_ctl.ack) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load on start, advance one bit per cycle while running
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.start) begin
            r_x    <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_RUN) begin
            r_x   <= {r_x[ERR_SUM_W-3:0], 2'b00};
            r_cnt <= r_cnt + CntW'(1);
            if (take) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy  = (r_state == ST_RUN);
    assign o_sts.valid = (r_state == ST_DONE);
    assign o_root      = r_root;

endmodule

// ===== hdl/pair_histogram_fold_accumulator.sv =====
// Top level of the pair histogram fold accumulator.
// Depends on phfa_pkg, phfa_ram (two bin stores) and phfa_sqrt (error root).
//
// Folds (eta1, phi1, eta2, phi2) source bins into (delta-eta, delta-phi) bins held
// in two 992-entry synchronous RAMs: a 41-bit saturating value sum and a 64-bit
// saturating sum of squared errors. Accumulate requests are taken one per cycle
// while the input is not stalled: the RAM read is issued at acceptance, the add
// and write-back follow in the next cycle, and a one-entry bypass of the last
// write covers back-to-back hits on the same bin. A read request returns the
// bin's value sum and the floor square root of its error-square sum and clears
// the bin; it occupies the block through acceptance, the RAM read, the bit-serial
// square-root iterations (one per root bit) and the output load; the next request
// is taken once the result has moved to the output register. Out-of-range reads
// return status 1 with zero fields through the same path. After reset both RAMs
// are zeroed by a clearing pass over all 992 entries, one entry per cycle, during
// which input requests are stalled; configuration writes are taken at any time.
module pair_histogram_fold_accumulator
    import phfa_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    // input requests
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [3:0]                  i_eta_first,
    input  logic [4:0]                  i_phi_first,
    input  logic [3:0]                  i_eta_second,
    input  logic [4:0]                  i_phi_second,
    input  logic signed [VAL_IN_W-1:0]  i_bin_value,
    input  logic [ERR_IN_W-1:0]         i_bin_error,
    input  logic [4:0]                  i_read_delta_eta,
    input  logic [4:0]                  i_read_delta_phi,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VAL_SUM_W-1:0] o_sum_value,
    output logic [ROOT_W-1:0]           o_sum_error,
    output logic                        o_status
);

    localparam logic signed [VAL_SUM_W-1:0] ValMax = {1'b0, {(VAL_SUM_W-1){1'b1}}};
    localparam logic signed [VAL_SUM_W-1:0] ValMin = {1'b1, {(VAL_SUM_W-1){1'b0}}};

    // Configuration registers
    logic [ETA_REG_W-1:0] r_eta_bins;
    logic [PHI_REG_W-1:0] r_phi_bins;

    // Clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // Update stage
    logic                       r_s1_valid;
    logic                       r_s1_mode;
    logic                       r_s1_bad;
    logic [ADDR_W-1:0]          r_s1_addr;
    logic signed [VAL_IN_W-1:0] r_s1_value;
    logic [SQ_W-1:0]            r_s1_sq;

    // Bypass of the last RAM write
    logic                 r_fw_valid;
    logic [ADDR_W-1:0]    r_fw_addr;
    logic [VAL_SUM_W-1:0] r_fw_val;
    logic [ERR_SUM_W-1:0] r_fw_err;

    // Read result waiting on the root
    logic [VAL_SUM_W-1:0] r_rd_value;
    logic                 r_rd_status;

    // Output register
    logic                 r_out_valid;
    logic [VAL_SUM_W-1:0] r_out_value;
    logic [ROOT_W-1:0]    r_out_error;
    logic                 r_out_status;

    logic [ETA_REG_W-1:0] eff_eta;
    logic [PHI_REG_W-1:0] eff_phi;
    logic                 in_fire;
    logic                 acc_ok;
    logic                 rd_bad;
    logic [5:0]           acc_de;
    logic [5:0]           acc_dp;
    logic [5:0]           rd_limit;
    logic [ADDR_W-1:0]    acc_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    in_addr;
    logic                 keep;
    logic [SQ_W-1:0]      n_sq;

    logic [VAL_SUM_W-1:0] ram_val;
    logic [ERR_SUM_W-1:0] ram_err;
    logic                 fw_hit;
    logic [VAL_SUM_W-1:0] old_val;
    logic [ERR_SUM_W-1:0] old_err;
    logic [VAL_SUM_W:0]   val_sum;
    logic [VAL_SUM_W-1:0] val_new;
    logic [ERR_SUM_W:0]   err_sum;
    logic [ERR_SUM_W-1:0] err_new;

    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [VAL_SUM_W-1:0] wval;
    logic [ERR_SUM_W-1:0] werr;

    t_sqrt_ctl            sq_ctl;
    t_sqrt_sts            sq_sts;
    logic [ROOT_W-1:0]    sq_root;
    logic                 out_load;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_bins <= ETA_BINS_RST;
            r_phi_bins <= PHI_BINS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ETA_BINS: r_eta_bins <= i_cfg_data[ETA_REG_W-1:0];
                CFG_PHI_BINS: r_phi_bins <= i_cfg_data[PHI_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp bin counts to the store geometry
    assign eff_eta = (r_eta_bins > ETA_REG_W'(MAX_ETA_BINS)) ? ETA_REG_W'(MAX_ETA_BINS)
                                                               : r_eta_bins;
    assign eff_phi = (r_phi_bins > PHI_REG_W'(MAX_PHI_BINS)) ? PHI_REG_W'(MAX_PHI_BINS)
                                                               : r_phi_bins;

    // Accept requests unless clearing or a read is in flight
    assign o_in_stall = r_clr_busy | (r_s1_valid & r_s1_mode) | sq_sts.busy | sq_sts.valid;
    assign in_fire    = i_in_valid & ~o_in_stall;

    // Fold accumulate coordinates
    assign acc_ok = ({1'b0, i_eta_first}  < eff_eta) && ({1'b0, i_eta_second} < eff_eta) &&
                    ({1'b0, i_phi_first}  < eff_phi) && ({1'b0, i_phi_second} < eff_phi);
    assign acc_de = 6'(i_eta_first) + 6'(eff_eta) - 6'd1 - 6'(i_eta_second);
    assign acc_dp = (i_phi_first >= i_phi_second)
                  ? 6'(i_phi_first) - 6'(i_phi_second)
                  : 6'(i_phi_first) + eff_phi - 6'(i_phi_second);
    assign acc_addr = ADDR_W'(acc_de[4:0]) * ADDR_W'(MAX_PHI_BINS) + ADDR_W'(acc_dp[4:0]);

    // Check the folded bin of a read
    assign rd_limit = {eff_eta, 1'b0} - 6'd1;
    assign rd_bad   = (eff_eta == '0) || ({1'b0, i_read_delta_eta} >= rd_limit) ||
                      ({1'b0, i_read_delta_phi} >= eff_phi);
    assign rd_addr  = ADDR_W'(i_read_delta_eta) * ADDR_W'(MAX_PHI_BINS) +
                      ADDR_W'(i_read_delta_phi);

    assign in_addr = (i_mode == MODE_READ) ? rd_addr : acc_addr;
    assign keep    = in_fire & ((i_mode == MODE_READ) | acc_ok);
    assign n_sq    = SQ_W'(i_bin_error) * SQ_W'(i_bin_error);

    // Register the request into the update stage; drop out-of-range accumulates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_mode  <= i_mode;
            r_s1_bad   <= (i_mode == MODE_READ) & rd_bad;
            r_s1_addr  <= in_addr;
            r_s1_value <= i_bin_value;
            r_s1_sq    <= n_sq;
        end
    end

    // Bin stores
    phfa_ram #(
        .WIDTH (VAL_SUM_W),
        .DEPTH (FOLD_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wval),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_val)
    );

    phfa_ram #(
        .WIDTH (ERR_SUM_W),
        .DEPTH (FOLD_DEPTH)
    ) u_err_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (werr),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_err)
    );

    // Take the last write instead of stale RAM data on a same-bin hit
    assign fw_hit  = r_fw_valid && (r_fw_addr == r_s1_addr);
    assign old_val = fw_hit ? r_fw_val : ram_val;
    assign old_err = fw_hit ? r_fw_err : ram_err;

    // Saturating value add
    assign val_sum = {old_val[VAL_SUM_W-1], old_val} +
                     (VAL_SUM_W+1)'(r_s1_value);
    always_comb begin
        if (val_sum[VAL_SUM_W] != val_sum[VAL_SUM_W-1]) begin
            val_new = val_sum[VAL_SUM_W] ? ValMin : ValMax;
        end else begin
            val_new = val_sum[VAL_SUM_W-1:0];
        end
    end

    // Saturating error-square add
    assign err_sum = {1'b0, old_err} + (ERR_SUM_W+1)'(r_s1_sq);
    assign err_new = err_sum[ERR_SUM_W] ? {ERR_SUM_W{1'b1}} : err_sum[ERR_SUM_W-1:0];

    // Write back: clearing pass, accumulate, or clear after read
    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wval  = '0;
            werr  = '0;
        end else begin
            we    = r_s1_valid & ~r_s1_bad;
            waddr = r_s1_addr;
            wval  = (r_s1_mode == MODE_READ) ? '0 : val_new;
            werr  = (r_s1_mode == MODE_READ) ? '0 : err_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_fw_addr <= waddr;
            r_fw_val  <= wval;
            r_fw_err  <= werr;
        end
    end

    // Sweep both stores to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(FOLD_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Launch the root for a read and hold its value sum and status
    assign sq_ctl.start = r_s1_valid & (r_s1_mode == MODE_READ);
    assign sq_ctl.ack   = out_load;

    always_ff @(posedge i_clk) begin
        if (sq_ctl.start) begin
            r_rd_value  <= r_s1_bad ? '0 : old_val;
            r_rd_status <= r_s1_bad;
        end
    end

    phfa_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (sq_ctl),
        .i_operand (r_s1_bad ? '0 : old_err),
        .o_sts     (sq_sts),
        .o_root    (sq_root)
    );

    // Output register: load a finished read when free, hold while stalled
    assign out_load = sq_sts.valid & (~r_out_valid | ~i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value  <= r_rd_value;
            r_out_error  <= sq_root;
            r_out_status <= r_rd_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum_value = r_out_value;
    assign o_sum_error = r_out_error;
    assign o_status    = r_out_status;

endmodule

// ===== hdl/phfa_checker.sv =====
// Port-level checker for the pair histogram fold accumulator, bound to the top level.
// Depends on phfa_pkg for field widths and the read mode code.
module phfa_checker
    import phfa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 i_mode,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [VAL_SUM_W-1:0] o_sum_value,
    input logic [ROOT_W-1:0]    o_sum_error,
    input logic                 o_status
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sum_value) && $stable(o_sum_error) &&
             $stable(o_status)))
        else $error("result changed while stalled");

    // A flagged read carries zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_sum_value == '0 && o_sum_error == '0))
        else $error("flagged result has nonzero fields");

    // An accepted read blocks the next request
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode == MODE_READ) |=> o_in_stall)
        else $error("request accepted behind a read");

    // A new result only follows a cycle with input stalled by a read
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pending read");

endmodule

bind pair_histogram_fold_accumulator phfa_checker u_phfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sum_value (o_sum_value),
    .o_sum_error (o_sum_error),
    .o_status    (o_status)
);
